// File: rtl/core/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared types and constants for the error code LED blinker.
// ----------------------------------------------------------------------------
package ecb_pkg;

  localparam int CODE_BITS_DEF  = 16;
  localparam int UNIT_W         = 16;
  localparam int LONG_W         = 3;
  localparam int TICK_W         = UNIT_W + LONG_W;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = UNIT_W'(200);
  localparam logic [LONG_W-1:0] LONG_UNITS_RST = LONG_W'(3);

  typedef enum logic {
    REG_UNIT_TICKS = 1'b0,
    REG_LONG_UNITS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_ON    = 3'd2,
    PH_GAP   = 3'd3,
    PH_CLOSE = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_ticks;
    logic [LONG_W-1:0] long_units;
  } cfg_t;

  typedef struct packed {
    logic led;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

// File: rtl/core/ecb_in_if.sv
// ----------------------------------------------------------------------------
// ecb_in_if
// Input channel: start and tick transactions.
// ----------------------------------------------------------------------------
interface ecb_in_if #(
  parameter int CODE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [CODE_BITS-1:0] code;

  modport source (output valid, output kind, output code, input ready);
  modport sink   (input valid, input kind, input code, output ready);
endinterface

// File: rtl/core/ecb_out_if.sv
// ----------------------------------------------------------------------------
// ecb_out_if
// Result channel: LED level and status per transaction.
// ----------------------------------------------------------------------------
interface ecb_out_if;
  logic valid;
  logic ready;
  logic led;
  logic busy_res;
  logic done_res;

  modport source (output valid, output led, output busy_res, output done_res, input ready);
  modport sink   (input valid, input led, input busy_res, input done_res, output ready);
endinterface

// File: rtl/core/ecb_cfg.sv
// ----------------------------------------------------------------------------
// ecb_cfg
// APB register block holding unit_ticks and long_units.
// ----------------------------------------------------------------------------
module ecb_cfg
  import ecb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [UNIT_W-1:0] unit_ticks_r;
  logic [LONG_W-1:0] long_units_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
      long_units_r <= LONG_UNITS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_UNIT_TICKS: unit_ticks_r <= pwdata[UNIT_W-1:0];
        REG_LONG_UNITS: long_units_r <= pwdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UNIT_TICKS: prdata = APB_DW'(unit_ticks_r);
      REG_LONG_UNITS: prdata = APB_DW'(long_units_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.unit_ticks = unit_ticks_r;
  assign cfg.long_units = long_units_r;

endmodule

// File: rtl/core/ecb_core.sv
// ----------------------------------------------------------------------------
// ecb_core
// Pattern sequencer: updates phase and timer per accepted transaction and
// forms its result.
// ----------------------------------------------------------------------------
module ecb_core
  import ecb_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [CODE_BITS-1:0] code,
  input  cfg_t                 cfg,
  output res_t                 res
);

  localparam int SL_W = $clog2(CODE_BITS);

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;
  logic [CODE_BITS-1:0] symbol_bits_r, symbol_bits_nxt;
  logic [SL_W-1:0]     symbols_left_r, symbols_left_nxt;
  logic                current_long_r, current_long_nxt;

  logic [CODE_BITS-1:0] mag;
  logic                 load_long;
  logic [SL_W-1:0]      top;
  logic [UNIT_W-1:0]    unit_len;
  logic [LONG_W-1:0]    mult;
  logic [TICK_W-1:0]    phase_len;
  logic [TICK_W-1:0]    tick_inc;
  logic [SL_W-1:0]      sl_dec;

  // magnitude: code when positive, 1 - code when negative
  always_comb begin
    if (code == '0) begin
      mag       = '0;
      load_long = 1'b0;
    end else if (code[CODE_BITS-1]) begin
      mag       = ~code + CODE_BITS'(2);
      load_long = 1'b0;
    end else begin
      mag       = code;
      load_long = 1'b1;
    end
  end

  always_comb begin
    top = '0;
    for (int i = 1; i < CODE_BITS; i++) begin
      if (mag[i]) top = SL_W'(i);
    end
  end

  assign unit_len  = (cfg.unit_ticks == '0) ? UNIT_W'(1) : cfg.unit_ticks;
  assign mult      = ((phase_r == PH_ON) && current_long_r) ?
                     ((cfg.long_units == '0) ? LONG_W'(1) : cfg.long_units) : LONG_W'(1);
  assign phase_len = TICK_W'(unit_len) * TICK_W'(mult);
  assign tick_inc  = tick_count_r + TICK_W'(1);
  assign sl_dec    = symbols_left_r - SL_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    symbol_bits_nxt  = symbol_bits_r;
    symbols_left_nxt = symbols_left_r;
    current_long_nxt = current_long_r;
    if (accept) begin
      if (kind == KIND_START) begin
        if (phase_r == PH_IDLE) begin
          symbol_bits_nxt  = mag;
          symbols_left_nxt = top;
          current_long_nxt = load_long;
          tick_count_nxt   = '0;
          phase_nxt        = PH_LEAD;
        end
      end else if (phase_r != PH_IDLE) begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= phase_len) begin
          tick_count_nxt = '0;
          case (phase_r)
            PH_LEAD: phase_nxt = PH_ON;
            PH_ON:   phase_nxt = PH_GAP;
            PH_GAP: begin
              if (symbols_left_r != '0) begin
                current_long_nxt = symbol_bits_r[sl_dec];
                symbols_left_nxt = sl_dec;
                phase_nxt        = PH_ON;
              end else begin
                phase_nxt = PH_CLOSE;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_comb begin
    res.done_res = 1'b0;
    if (kind == KIND_START) begin
      res.led      = (phase_nxt == PH_ON);
      res.busy_res = 1'b1;
    end else begin
      res.led      = (phase_r == PH_ON);
      res.busy_res = (phase_r != PH_IDLE);
      res.done_res = (phase_r == PH_CLOSE) && (phase_nxt == PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      tick_count_r   <= '0;
      symbol_bits_r  <= '0;
      symbols_left_r <= '0;
      current_long_r <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      symbol_bits_r  <= symbol_bits_nxt;
      symbols_left_r <= symbols_left_nxt;
      current_long_r <= current_long_nxt;
    end
  end

endmodule

// File: rtl/core/ecb_skid.sv
// ----------------------------------------------------------------------------
// ecb_skid
// Two-entry result buffer between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module ecb_skid
  import ecb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  res_t             push_data,
  output logic             push_ready,
  ecb_out_if.source        out_ch
);

  logic [1:0] count_r, count_nxt;
  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic       pop;

  assign pop        = out_ch.valid && out_ch.ready;
  assign push_ready = (count_r != 2'd2);

  always_comb begin
    count_nxt = count_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    if (push && !pop) begin
      if (count_r == 2'd0) e0_nxt = push_data;
      else                 e1_nxt = push_data;
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      e0_nxt    = e1_r;
      count_nxt = count_r - 2'd1;
    end else if (push && pop) begin
      if (count_r == 2'd1) begin
        e0_nxt = push_data;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 2'd0;
    else        count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_ch.valid    = (count_r != 2'd0);
  assign out_ch.led      = e0_r.led;
  assign out_ch.busy_res = e0_r.busy_res;
  assign out_ch.done_res = e0_r.done_res;

endmodule

// File: rtl/core/error_code_led_blinker.sv
// ----------------------------------------------------------------------------
// error_code_led_blinker
// Shows a signed error code on an LED as a binary Morse pattern.
// ----------------------------------------------------------------------------
// One start or tick transaction is taken every clock; each yields one result
// transaction, registered into a two-entry output buffer, so the input only
// stalls when it is full. The rate is set by the sequencer's phase and timer
// update. The user is to write unit_ticks (0x0) and long_units (0x4)
// over APB while no transaction is in flight; the block does not enforce it.
// A new value applies from the next tick, also in the middle of a pattern.
module error_code_led_blinker
  import ecb_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  ecb_in_if.sink            in_ch,
  ecb_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t res;
  logic accept;
  logic push_ready;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ecb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ecb_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_ch.kind),
    .code   (in_ch.code),
    .cfg    (cfg),
    .res    (res)
  );

  ecb_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> out_ch.busy_res)
    else $error("done without busy");

  a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.led) |-> out_ch.busy_res)
    else $error("led on while idle");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted transaction produced no result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the error code LED blinker. Start and tick transactions go in with
// random gaps, and results come out under random stalls and one long
// hold-off. A local mirror of the pattern sequencer predicts every result,
// and each result is compared field by field. The two timing registers are
// written over APB across several settings, zero and full scale included.
// ----------------------------------------------------------------------------
module testbench;
  import ecb_pkg::*;

  localparam int CB          = CODE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ecb_in_if #(.CODE_BITS(CB)) in_ch ();
  ecb_out_if                  out_ch ();

  error_code_led_blinker #(.CODE_BITS(CB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // sequencer mirror
  phase_t            bl_phase = PH_IDLE;
  int unsigned       bl_ticks = 0;
  logic [CB:0]       bl_bits  = '0;
  int unsigned       bl_left  = 0;
  logic              bl_long  = 1'b0;
  logic [UNIT_W-1:0] unit_reg = UNIT_TICKS_RST;
  logic [LONG_W-1:0] long_reg = LONG_UNITS_RST;

  res_t led_q[$];
  res_t want;
  int   err_cnt     = 0;
  int   cycle_cnt   = 0;
  int   hold_len    = 0;
  int   live_items  = 0;
  bit   idle_en     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned phase_ticks();
    int unsigned u;
    int unsigned m;
    u = (unit_reg == 0) ? 1 : unit_reg;
    m = (long_reg == 0) ? 1 : long_reg;
    if (bl_phase == PH_ON && bl_long) return u * m;
    return u;
  endfunction

  function automatic void load_pattern(logic signed [CB-1:0] c);
    logic [CB:0] mag;
    int          top;
    top = -1;
    if (c == 0) begin
      mag     = '0;
      bl_long = 1'b0;
    end else if (c < 0) begin
      mag     = 1 - {c[CB-1], c};
      bl_long = 1'b0;
    end else begin
      mag     = {1'b0, c};
      bl_long = 1'b1;
    end
    for (int i = CB; i >= 0; i--)
      if (mag[i] && top < 0) top = i;
    bl_bits  = mag;
    bl_left  = (top > 0) ? top : 0;
    bl_ticks = 0;
    bl_phase = PH_LEAD;
  endfunction

  function automatic res_t blinker_step(kind_t k, logic signed [CB-1:0] c);
    res_t r;
    r = '0;
    if (k == KIND_START) begin
      if (bl_phase == PH_IDLE) load_pattern(c);
      r.led      = (bl_phase == PH_ON);
      r.busy_res = (bl_phase != PH_IDLE);
      return r;
    end
    if (bl_phase == PH_IDLE) return r;
    r.led      = (bl_phase == PH_ON);
    r.busy_res = 1'b1;
    bl_ticks++;
    if (bl_ticks >= phase_ticks()) begin
      bl_ticks = 0;
      case (bl_phase)
        PH_LEAD: bl_phase = PH_ON;
        PH_ON:   bl_phase = PH_GAP;
        PH_GAP: begin
          if (bl_left > 0) begin
            bl_long  = bl_bits[bl_left-1];
            bl_left--;
            bl_phase = PH_ON;
          end else begin
            bl_phase = PH_CLOSE;
          end
        end
        default: begin
          r.done_res = 1'b1;
          bl_phase   = PH_IDLE;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [CB-1:0] rand_code();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       v = -32768;
          1:       v = -32767;
          2:       v = -1;
          3:       v = 0;
          4:       v = 1;
          default: v = 32767;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 31)) - 16;
      default: v = $urandom();
    endcase
    return CB'(v);
  endfunction

  task automatic send_item(kind_t k, logic signed [CB-1:0] c);
    int gap;
    gap = idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.code  <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (!(k == KIND_START && bl_phase != PH_IDLE)) live_items++;
    led_q.push_back(blinker_step(k, c));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, CB'($urandom()));
  endtask

  task automatic send_start(logic signed [CB-1:0] c);
    send_item(KIND_START, c);
  endtask

  task automatic finish_pattern();
    while (bl_phase != PH_IDLE) send_tick();
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
    in_ch.valid <= 1'b0;
    while (led_q.size() != 0) @(posedge clk);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UNIT_TICKS: unit_reg = val[UNIT_W-1:0];
      default:        long_reg = val[LONG_W-1:0];
    endcase
  endtask

  task automatic run_pattern(logic signed [CB-1:0] c);
    send_start(c);
    while (bl_phase != PH_IDLE) begin
      if ($urandom_range(0, 19) == 0) send_start(rand_code());
      else send_tick();
    end
    if ($urandom_range(0, 3) == 0) send_tick();
  endtask

  task automatic test_idle_ticks();
    send_tick();
    send_tick();
  endtask

  // start ignored while busy; unit length changes under a running lead-in
  task automatic test_busy_start_and_live_write();
    send_start(CB'(3));
    repeat (5) send_tick();
    send_start(-CB'(7));
    write_reg(REG_UNIT_TICKS, 32'd65535);
    send_tick();
    send_tick();
    write_reg(REG_UNIT_TICKS, 32'd1);
    write_reg(REG_LONG_UNITS, 32'd1);
    finish_pattern();
  endtask

  task automatic test_zero_registers();
    write_reg(REG_UNIT_TICKS, 32'd0);
    write_reg(REG_LONG_UNITS, 32'd0);
    send_start(CB'(0));
    finish_pattern();
    send_start(CB'(1));
    finish_pattern();
  endtask

  task automatic test_backpressure();
    write_reg(REG_UNIT_TICKS, 32'd1);
    write_reg(REG_LONG_UNITS, 32'd7);
    idle_en  = 1'b0;
    hold_len = HOLD_CYCLES;
    send_start(rand_code());
    repeat (20) send_tick();
    idle_en = 1'b1;
  endtask

  task automatic test_random_patterns();
    int target;
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_UNIT_TICKS, (p == 3) ? 32'd0 : $urandom_range(1, 2));
      write_reg(REG_LONG_UNITS, (p == 1) ? 32'd7 : (p == 2) ? 32'd1 : $urandom_range(0, 7));
      idle_en = (p % 3 != 2);
      target  = live_items + 60;
      while (live_items < target) run_pattern(rand_code());
    end
    idle_en = 1'b1;
  endtask

  // result side: random stall per transaction, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (led_q.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        want = led_q.pop_front();
        if (out_ch.led !== want.led) begin
          $error("led: expected %0d, actual %0d", want.led, out_ch.led);
          err_cnt++;
        end
        if (out_ch.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, actual %0d", want.busy_res, out_ch.busy_res);
          err_cnt++;
        end
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0d, actual %0d", want.done_res, out_ch.done_res);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_TICK;
    in_ch.code  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_busy_start_and_live_write();
    test_zero_registers();
    test_backpressure();
    test_random_patterns();

    in_ch.valid <= 1'b0;
    while (led_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
